FILE: design/jvfe_pkg.sv
// jvfe_pkg: shared types and constants of the json value field extractor
// byte classes, status codes, type modes, register indexes, queue item formats
`default_nettype none

package jvfe_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 2;
    localparam logic [15:0] CAPACITY_RESET = 16'd64;

    // configuration register indexes
    localparam logic [1:0] CFG_VALUE_TYPE = 2'd0;
    localparam logic [1:0] CFG_CAPACITY   = 2'd1;

    // value type modes
    localparam logic [2:0] TYPE_STR  = 3'd0;
    localparam logic [2:0] TYPE_SINT = 3'd1;
    localparam logic [2:0] TYPE_UINT = 3'd2;
    localparam logic [2:0] TYPE_BOOL = 3'd3;
    localparam logic [2:0] TYPE_REAL = 3'd4;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_NULL    = 3'd2,
        ST_ILLEGAL = 3'd3,
        ST_LONG    = 3'd4
    } t_status;

    // byte class, resolved against the type mode in the front end
    typedef enum logic [3:0] {
        CL_NUL      = 4'd0,
        CL_SKIP     = 4'd1,
        CL_SPACE    = 4'd2,
        CL_TERM_STR = 4'd3,
        CL_TERM_END = 4'd4,
        CL_COPY     = 4'd5,
        CL_ILLEGAL  = 4'd6,
        CL_QUOTE    = 4'd7,
        CL_BSLASH   = 4'd8,
        CL_STRCHAR  = 4'd9
    } t_cls;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       start;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [7:0]  value_byte;
        logic        value_valid;
        logic        finished;
        t_status     status;
        logic [15:0] value_length;
        logic [15:0] consumed;
    } t_result;

endpackage

`default_nettype wire

FILE: design/jvfe_fifo.sv
// jvfe_fifo: small register queue with push/full and pop/empty sides
// generic width and depth, no package dependency
`default_nettype none

module jvfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/jvfe_front.sv
// jvfe_front: classifies each incoming text byte against the type mode
// and queues it for the back end; uses jvfe_pkg and jvfe_fifo
`default_nettype none

module jvfe_front #(
    parameter int DEPTH = jvfe_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_value_type,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_source_byte,
    input  wire logic          i_start_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output jvfe_pkg::t_item    o_item,
    output logic               o_empty
);
    import jvfe_pkg::*;

    t_item w_item;
    logic  w_str, w_real, w_sint;

    assign w_str  = (i_value_type == TYPE_STR);
    assign w_real = (i_value_type == TYPE_REAL);
    assign w_sint = (i_value_type == TYPE_SINT);

    always_comb begin
        t_cls cls;
        cls = CL_ILLEGAL;
        if (i_value_type > TYPE_REAL) begin
            cls = CL_ILLEGAL;
        end else if (i_source_byte == 8'h00) begin
            cls = CL_NUL;
        end else if (i_source_byte inside {8'h09, 8'h0a, 8'h0d}) begin
            cls = CL_SKIP;
        end else if (i_source_byte inside {8'h20, 8'h3a}) begin
            cls = CL_SPACE;
        end else if (i_source_byte inside {8'h2c, 8'h7d}) begin
            cls = w_str ? CL_TERM_STR : CL_TERM_END;
        end else if (i_source_byte == 8'h2e) begin
            cls = (w_str || w_real) ? CL_COPY : CL_ILLEGAL;
        end else if (i_source_byte == 8'h2d) begin
            cls = (w_str || w_sint || w_real) ? CL_COPY : CL_ILLEGAL;
        end else if (i_source_byte == 8'h22) begin
            cls = w_str ? CL_QUOTE : CL_ILLEGAL;
        end else if (i_source_byte == 8'h5c) begin
            cls = w_str ? CL_BSLASH : CL_ILLEGAL;
        end else if (w_str) begin
            cls = CL_STRCHAR;
        end else if (i_value_type == TYPE_BOOL) begin
            // letters of true and false
            cls = (i_source_byte inside {8'h74, 8'h72, 8'h75, 8'h65,
                                         8'h66, 8'h61, 8'h6c, 8'h73})
                  ? CL_COPY : CL_ILLEGAL;
        end else begin
            cls = (i_source_byte inside {[8'h30:8'h39]}) ? CL_COPY : CL_ILLEGAL;
        end
        w_item.src_byte = i_source_byte;
        w_item.start    = i_start_req;
        w_item.cls      = cls;
    end

    jvfe_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

FILE: design/jvfe_back.sv
// jvfe_back: applies classified bytes to the extraction state and queues results
// uses jvfe_pkg and jvfe_fifo
`default_nettype none

module jvfe_back #(
    parameter int COUNT_WIDTH = jvfe_pkg::COUNT_WIDTH_DEF,
    parameter int DEPTH       = jvfe_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_capacity,
    input  wire logic          i_item_avail,
    input  jvfe_pkg::t_item    i_item,
    output logic               o_item_take,
    input  wire logic          i_pop,
    output jvfe_pkg::t_result  o_result,
    output logic               o_empty
);
    import jvfe_pkg::*;

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_active, n_active;
    logic [1:0]             r_quote, n_quote;
    logic                   r_escape, n_escape;
    logic [COUNT_WIDTH-1:0] r_copied, n_copied;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;

    logic    w_out_full;
    t_result w_result;

    assign o_item_take = i_item_avail && !w_out_full;

    always_comb begin
        logic    copy;
        t_status status;
        copy     = 1'b0;
        status   = ST_RUN;
        n_active = r_active;
        n_quote  = r_quote;
        n_escape = r_escape;
        n_copied = r_copied;
        n_bytes  = r_bytes;
        if (i_item.start) begin
            n_active = 1'b1;
            n_quote  = '0;
            n_escape = 1'b0;
            n_copied = '0;
            n_bytes  = '0;
        end
        if (n_active) begin
            if (n_bytes != CNT_MAX) begin
                n_bytes = n_bytes + 1'b1;
            end
            case (i_item.cls)
                CL_NUL:      status = ST_NULL;
                CL_SKIP:     ;
                CL_SPACE:    copy = (n_quote == 2'd1);
                CL_TERM_STR: begin
                    if (n_quote < 2'd2) copy = 1'b1;
                    else status = ST_DONE;
                end
                CL_TERM_END: status = ST_DONE;
                CL_COPY:     copy = 1'b1;
                CL_ILLEGAL:  status = ST_ILLEGAL;
                CL_QUOTE: begin
                    if (n_escape) copy = 1'b1;
                    else if (n_quote > 2'd1) status = ST_ILLEGAL;
                    else n_quote = n_quote + 1'b1;
                end
                CL_BSLASH: begin
                    if (n_escape) copy = 1'b1;
                    else n_escape = 1'b1;
                end
                CL_STRCHAR: begin
                    if (n_quote != 2'd0) copy = 1'b1;
                    else status = ST_ILLEGAL;
                end
                default:     status = ST_ILLEGAL;
            endcase
            if (copy) begin
                if ((CMPW'(n_copied) < CMPW'(i_capacity)) && (n_copied != CNT_MAX)) begin
                    n_copied = n_copied + 1'b1;
                    if (i_item.cls == CL_QUOTE || i_item.cls == CL_BSLASH) begin
                        n_escape = 1'b0;
                    end
                end else begin
                    copy   = 1'b0;
                    status = ST_LONG;
                end
            end
            if (status != ST_RUN) begin
                n_active = 1'b0;
            end
        end
        w_result.value_byte   = copy ? i_item.src_byte : 8'h00;
        w_result.value_valid  = copy;
        w_result.finished     = (status != ST_RUN);
        w_result.status       = status;
        w_result.value_length = 16'(n_copied);
        w_result.consumed     = 16'(n_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_quote  <= '0;
            r_escape <= 1'b0;
            r_copied <= '0;
            r_bytes  <= '0;
        end else if (o_item_take) begin
            r_active <= n_active;
            r_quote  <= n_quote;
            r_escape <= n_escape;
            r_copied <= n_copied;
            r_bytes  <= n_bytes;
        end
    end

    jvfe_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_item_take),
        .i_data  (w_result),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

FILE: design/json_value_field_extractor_core.sv
// json value field extractor, top level
// takes json text bytes that follow a matched key and copies out the value text
// input channel: push/full, one text byte and a start flag per transaction;
// start_req clears the extraction state and opens a new value with that byte
// result channel: empty/pop, one result per input byte, oldest first, with the
// copied byte (if any), finished flag, status, copied length and bytes consumed
// config channel: i_cfg_valid/o_cfg_ready, index 0 value type, 1 capacity;
// o_cfg_ready is always high; the user must see that writes are made only while
// no byte is in flight, and the block itself does not enforce this
// throughput: one byte per cycle while the output queue is not full, set by the
// state update in the back end; the front classifier and back end are parted
// by a two-entry queue and results sit in a two-entry output queue
// receiver stall: results pile up in the output queue, the back end then holds,
// the front queue fills and full rises; nothing is dropped
// reset: both queues empty, value type 0, capacity 64, extraction idle;
// there is no clearing pass
`default_nettype none

module json_value_field_extractor_core #(
    parameter int COUNT_WIDTH = jvfe_pkg::COUNT_WIDTH_DEF,
    parameter int FIFO_DEPTH  = jvfe_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_start_req,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_value_byte,
    output logic             o_value_valid,
    output logic             o_finished,
    output logic [2:0]       o_status,
    output logic [15:0]      o_value_length,
    output logic [15:0]      o_consumed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import jvfe_pkg::*;

    logic [2:0]  r_value_type;
    logic [15:0] r_capacity;
    t_item       w_item;
    logic        w_item_empty;
    logic        w_item_take;
    t_result     w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_type <= TYPE_STR;
            r_capacity   <= CAPACITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VALUE_TYPE: r_value_type <= i_cfg_data[2:0];
                CFG_CAPACITY:   r_capacity   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    jvfe_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_type  (r_value_type),
        .i_push        (push),
        .i_source_byte (i_source_byte),
        .i_start_req   (i_start_req),
        .o_full        (full),
        .i_pop         (w_item_take),
        .o_item        (w_item),
        .o_empty       (w_item_empty)
    );

    jvfe_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DEPTH       (FIFO_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (r_capacity),
        .i_item_avail (!w_item_empty),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .i_pop        (pop),
        .o_result     (w_result),
        .o_empty      (empty)
    );

    assign o_value_byte   = w_result.value_byte;
    assign o_value_valid  = w_result.value_valid;
    assign o_finished     = w_result.finished;
    assign o_status       = w_result.status;
    assign o_value_length = w_result.value_length;
    assign o_consumed     = w_result.consumed;

endmodule

`default_nettype wire

FILE: design/jvfe_checker.sv
// jvfe_checker: port-level checks of the extractor core, attached by bind
// uses jvfe_pkg status codes
`default_nettype none

module jvfe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic [7:0]  o_value_byte,
    input wire logic        o_value_valid,
    input wire logic        o_finished,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_value_length
);
    import jvfe_pkg::*;

    // a copied byte never ends the value
    a_copy_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_value_valid) |-> !o_finished)
        else $error("copied byte flagged as finished");

    // finished and a non-running status go together
    a_finished_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_finished == (o_status != ST_RUN)))
        else $error("finished flag disagrees with status");

    // no byte shown without a copy
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_value_valid) |-> (o_value_byte == 8'h00))
        else $error("value byte nonzero without a copy");

    // a copy always counts at least one character
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_value_valid) |-> (o_value_length != 16'd0))
        else $error("copied byte with zero length");

    // reset leaves both sides of the block empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind json_value_field_extractor_core jvfe_checker u_jvfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .o_value_byte   (o_value_byte),
    .o_value_valid  (o_value_valid),
    .o_finished     (o_finished),
    .o_status       (o_status),
    .o_value_length (o_value_length)
);

`default_nettype wire

FILE: tb/sv/json_value_field_extractor_core_tb.sv
// self-checking testbench for json_value_field_extractor_core
// depends on jvfe_pkg and the core; predicts every result from its own copy of
// the extraction state and checks each popped transaction field by field
`timescale 1ns / 1ps

module json_value_field_extractor_core_tb;

    import jvfe_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] COUNT_TOP = 16'hFFFF;

    // indexes that decode to no register
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic [7:0]  i_source_byte = 8'h00;
    logic        i_start_req   = 1'b0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [7:0]  o_value_byte;
    logic        o_value_valid;
    logic        o_finished;
    logic [2:0]  o_status;
    logic [15:0] o_value_length;
    logic [15:0] o_consumed;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [15:0] i_cfg_data    = 16'h0000;

    json_value_field_extractor_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_source_byte  (i_source_byte),
        .i_start_req    (i_start_req),
        .empty          (empty),
        .pop            (pop),
        .o_value_byte   (o_value_byte),
        .o_value_valid  (o_value_valid),
        .o_finished     (o_finished),
        .o_status       (o_status),
        .o_value_length (o_value_length),
        .o_consumed     (o_consumed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // extraction state and register copies
    logic        ex_active   = 1'b0;
    logic [1:0]  ex_quotes   = 2'd0;
    logic        ex_escape   = 1'b0;
    logic [15:0] ex_copied   = 16'd0;
    logic [15:0] ex_consumed = 16'd0;
    logic [2:0]  cfg_type     = TYPE_STR;
    logic [15:0] cfg_capacity = CAPACITY_RESET;
    logic        byte_was_live;

    t_result    extract_q[$];
    logic [7:0] txt_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    int err_count    = 0;
    int byte_count   = 0;
    int live_count   = 0;
    int value_count  = 0;
    int copy_count   = 0;
    int stall_count  = 0;
    int cfg_count    = 0;
    int end_count[5] = '{0, 0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("json_value_field_extractor_core_tb: errors");
        $finish;
    end

    function automatic logic is_flag_letter(input logic [7:0] c);
        case (c)
            "t", "r", "u", "e", "f", "a", "l", "s": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // advances the extraction state by one byte and returns its result
    function automatic t_result extract_byte(input logic [7:0] c, input logic s);
        t_result r;
        logic    take;
        t_status st;
        take = 1'b0;
        st   = ST_RUN;
        if (s) begin
            ex_active   = 1'b1;
            ex_quotes   = 2'd0;
            ex_escape   = 1'b0;
            ex_copied   = 16'd0;
            ex_consumed = 16'd0;
        end
        byte_was_live = ex_active;
        if (ex_active) begin
            if (ex_consumed != COUNT_TOP)
                ex_consumed = ex_consumed + 16'd1;
            if (cfg_type > TYPE_REAL) begin
                st = ST_ILLEGAL;
            end else if (c == CH_NUL) begin
                st = ST_NULL;
            end else if (c == CH_TAB || c == CH_CR || c == CH_LF) begin
                // dropped
            end else if (c == CH_SPACE || c == CH_COLON) begin
                take = (ex_quotes == 2'd1);
            end else if (c == CH_COMMA || c == CH_RBRACE) begin
                if (cfg_type == TYPE_STR && ex_quotes < 2'd2)
                    take = 1'b1;
                else
                    st = ST_DONE;
            end else if (c == CH_DOT) begin
                if (cfg_type == TYPE_STR || cfg_type == TYPE_REAL)
                    take = 1'b1;
                else
                    st = ST_ILLEGAL;
            end else if (c == CH_HYPHEN) begin
                if (cfg_type == TYPE_STR || cfg_type == TYPE_SINT ||
                    cfg_type == TYPE_REAL)
                    take = 1'b1;
                else
                    st = ST_ILLEGAL;
            end else if (c == CH_QUOTE) begin
                if (cfg_type != TYPE_STR)
                    st = ST_ILLEGAL;
                else if (ex_escape)
                    take = 1'b1;
                else if (ex_quotes > 2'd1)
                    st = ST_ILLEGAL;
                else
                    ex_quotes = ex_quotes + 2'd1;
            end else if (c == CH_BSLASH) begin
                if (cfg_type != TYPE_STR)
                    st = ST_ILLEGAL;
                else if (ex_escape)
                    take = 1'b1;
                else
                    ex_escape = 1'b1;
            end else if (cfg_type == TYPE_STR) begin
                if (ex_quotes > 2'd0)
                    take = 1'b1;
                else
                    st = ST_ILLEGAL;
            end else if (cfg_type == TYPE_BOOL) begin
                if (is_flag_letter(c))
                    take = 1'b1;
                else
                    st = ST_ILLEGAL;
            end else begin
                if (c >= "0" && c <= "9")
                    take = 1'b1;
                else
                    st = ST_ILLEGAL;
            end

            if (take) begin
                if (ex_copied < cfg_capacity && ex_copied != COUNT_TOP) begin
                    ex_copied = ex_copied + 16'd1;
                    // a copied quote or backslash closes the escape
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        ex_escape = 1'b0;
                end else begin
                    take = 1'b0;
                    st   = ST_LONG;
                end
            end
            if (st != ST_RUN)
                ex_active = 1'b0;
        end
        r.value_byte   = take ? c : 8'h00;
        r.value_valid  = take;
        r.finished     = (st != ST_RUN);
        r.status       = st;
        r.value_length = ex_copied;
        r.consumed     = ex_consumed;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic s);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_source_byte <= c;
        i_start_req   <= s;
        @(posedge i_clk);
        while (full) begin
            stall_count++;
            @(posedge i_clk);
        end
        extract_q.push_back(extract_byte(c, s));
        byte_count++;
        if (byte_was_live)
            live_count++;
        if (s)
            value_count++;
    endtask

    // waits until every expected transaction has been popped and the core is quiet
    task automatic settle();
        push <= 1'b0;
        while (extract_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VALUE_TYPE)
            cfg_type = d[2:0];
        else if (idx == CFG_CAPACITY)
            cfg_capacity = d;
        cfg_count++;
    endtask

    task automatic check_result();
        t_result want;
        if (extract_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: unexpected result byte %h valid %b status %0d", $realtime,
                         o_value_byte, o_value_valid, o_status);
            return;
        end
        want = extract_q.pop_front();
        if (o_value_byte !== want.value_byte || o_value_valid !== want.value_valid ||
            o_finished !== want.finished || o_status !== want.status ||
            o_value_length !== want.value_length || o_consumed !== want.consumed) begin
            err_count++;
            if (err_count <= 10)
                $display({"%0t: mismatch exp byte %h v %b f %b st %0d len %0d cons %0d,",
                          " got %h %b %b %0d %0d %0d"},
                         $realtime, want.value_byte, want.value_valid, want.finished,
                         want.status, want.value_length, want.consumed, o_value_byte,
                         o_value_valid, o_finished, o_status, o_value_length, o_consumed);
        end
        if (want.value_valid)
            copy_count++;
        if (want.finished)
            end_count[want.status]++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            check_result();
        pop <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        if (c == CH_QUOTE || c == CH_BSLASH)
            c = "x";
        return c;
    endfunction

    task automatic push_digits(input int n);
        repeat (n) txt_q.push_back(8'("0" + $urandom_range(9)));
    endtask

    task automatic push_text_char();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            txt_q.push_back(CH_BSLASH);
            case ($urandom_range(2))
                0: txt_q.push_back(CH_QUOTE);
                1: txt_q.push_back(CH_BSLASH);
                default: txt_q.push_back("n");
            endcase
        end else if (r < 14) begin
            txt_q.push_back($urandom_range(1) ? CH_SPACE : CH_COLON);
        end else if (r < 20) begin
            txt_q.push_back($urandom_range(1) ? CH_COMMA : CH_RBRACE);
        end else if (r < 26) begin
            txt_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            txt_q.push_back(pick_plain());
        end
    endtask

    // builds one value of the current type into txt_q, now and then damaged
    task automatic make_value();
        int k;
        txt_q.delete();
        if ($urandom_range(3) == 0)
            txt_q.push_back(pick_blank());
        case (cfg_type)
            TYPE_SINT: begin
                if ($urandom_range(1))
                    txt_q.push_back(CH_HYPHEN);
                push_digits($urandom_range(1, 6));
            end
            TYPE_UINT: push_digits($urandom_range(1, 6));
            TYPE_REAL: begin
                if ($urandom_range(1))
                    txt_q.push_back(CH_HYPHEN);
                push_digits($urandom_range(1, 4));
                txt_q.push_back(CH_DOT);
                push_digits($urandom_range(0, 4));
            end
            TYPE_BOOL: begin
                if ($urandom_range(1)) begin
                    txt_q.push_back("t");
                    txt_q.push_back("r");
                    txt_q.push_back("u");
                    txt_q.push_back("e");
                end else begin
                    txt_q.push_back("f");
                    txt_q.push_back("a");
                    txt_q.push_back("l");
                    txt_q.push_back("s");
                    txt_q.push_back("e");
                end
            end
            default: begin
                txt_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 12)) push_text_char();
                txt_q.push_back(CH_QUOTE);
            end
        endcase
        if ($urandom_range(3) == 0)
            txt_q.push_back(pick_blank());
        txt_q.push_back($urandom_range(1) ? CH_COMMA : CH_RBRACE);
        if ($urandom_range(99) < 12) begin
            k = $urandom_range(txt_q.size() - 1);
            txt_q[k] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic send_text();
        foreach (txt_q[i])
            send_byte(txt_q[i], i == 0);
    endtask

    task automatic pick_config();
        logic [2:0]  vt;
        logic [15:0] cap;
        int          r;
        vt = ($urandom_range(99) < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        r  = $urandom_range(99);
        if (r < 10)
            cap = 16'd0;
        else if (r < 20)
            cap = COUNT_TOP;
        else if (r < 30)
            cap = 16'($urandom_range(0, 65535));
        else
            cap = 16'($urandom_range(1, 24));
        write_reg(CFG_VALUE_TYPE, {13'd0, vt});
        write_reg(CFG_CAPACITY, cap);
    endtask

    task automatic test_string_value();
        send_byte(CH_QUOTE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);      // escaped quote is kept
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_COMMA, 1'b0);      // inside the quotes, so copied
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
    endtask

    task automatic test_idle_bytes();
        send_byte("x", 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic test_numeric_modes();
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_SINT});
        send_byte(CH_HYPHEN, 1'b1);
        send_byte("9", 1'b0);
        send_byte(CH_COMMA, 1'b0);
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_UINT});
        send_byte("5", 1'b1);
        send_byte(CH_HYPHEN, 1'b0);
        send_byte(CH_NUL, 1'b1);
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_BOOL});
        send_byte("t", 1'b1);
        send_byte("x", 1'b0);
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_REAL});
        write_reg(CFG_CAPACITY, 16'd2);
        send_byte("1", 1'b1);
        send_byte(CH_DOT, 1'b0);
        send_byte("5", 1'b0);
    endtask

    task automatic test_capacity_limits();
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_STR});
        write_reg(CFG_CAPACITY, 16'd0);
        write_reg(CFG_SPARE_LO, COUNT_TOP);
        write_reg(CFG_SPARE_HI, COUNT_TOP);
        send_byte(CH_QUOTE, 1'b1);
        send_byte("a", 1'b0);
    endtask

    task automatic test_unknown_type();
        write_reg(CFG_VALUE_TYPE, 16'd7);
        send_byte("a", 1'b1);
    endtask

    // receiver holds off while the sender keeps offering, so full must rise
    task automatic test_back_pressure();
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_STR});
        write_reg(CFG_CAPACITY, CAPACITY_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles <= 150;
        send_byte(CH_QUOTE, 1'b1);
        repeat (40) send_byte(pick_plain(), 1'b0);
        settle();
    endtask

    task automatic test_random_values(input int n_items);
        int target;
        target = byte_count + n_items;
        while (byte_count < target) begin
            pick_config();
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(99) < 8) begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
                end else begin
                    make_value();
                    send_text();
                end
            end
        end
    endtask

    // one value that runs past a large capacity and ends as too long
    task automatic test_long_value();
        write_reg(CFG_VALUE_TYPE, {13'd0, TYPE_STR});
        write_reg(CFG_CAPACITY, 16'd100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(CH_QUOTE, 1'b1);
        repeat (120) send_byte(pick_plain(), 1'b0);
        settle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 50;
        test_string_value();
        test_idle_bytes();
        test_numeric_modes();
        test_capacity_limits();
        test_unknown_type();
        test_back_pressure();

        send_idle_pct = 7;
        recv_idle_pct = 50;
        test_random_values(550);
        send_idle_pct = 50;
        recv_idle_pct = 7;
        test_random_values(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_values(550);

        test_long_value();
        settle();

        $display({"run: %0d bytes (%0d inside a value), %0d values, %0d copied,",
                  " %0d stall cycles, %0d register writes"},
                 byte_count, live_count, value_count, copy_count, stall_count, cfg_count);
        $display("value endings: done %0d, nul %0d, illegal %0d, too long %0d; %0d mismatches",
                 end_count[ST_DONE], end_count[ST_NULL], end_count[ST_ILLEGAL],
                 end_count[ST_LONG], err_count);
        if (err_count == 0)
            $display("json_value_field_extractor_core_tb: clean");
        else
            $display("json_value_field_extractor_core_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/jvfe_pkg.sv
design/jvfe_fifo.sv
design/jvfe_front.sv
design/jvfe_back.sv
design/json_value_field_extractor_core.sv
design/jvfe_checker.sv
tb/sv/json_value_field_extractor_core_tb.sv
